>>> src/sqmm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the square matrix multiplier.
// Used by sqmm_ctrl, sqmm_datapath and square_matrix_multiply; depends on nothing.
package sqmm_pkg;

	localparam int PRODUCT_W  = 21;
	localparam int INDEX_W    = 5;
	localparam int SIZE_W     = 6;
	localparam int SIZE_RESET = 16;

	localparam logic CMD_B = 1'b0;
	localparam logic CMD_A = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	typedef struct packed {
		logic load_b;
		logic load_a;
		logic mac_step;
		logic elem_done;
		logic emit_load;
	} ctrl_t;

	typedef struct packed {
		logic j_last;
		logic k_last;
		logic out_free;
	} stat_t;

endpackage

>>> src/sqmm_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the square matrix multiplier.
// Depends on sqmm_pkg for the state, command and status types.
module sqmm_ctrl import sqmm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  cmd,
	output logic  in_ready,
	output ctrl_t ctrl,
	input  stat_t stat
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ctrl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (cmd == CMD_B) begin
						ctrl.load_b = 1'b1;
					end else begin
						ctrl.load_a = 1'b1;
						state_d     = ST_MAC;
					end
				end
			end
			ST_MAC: begin
				ctrl.mac_step = 1'b1;
				if (stat.j_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				ctrl.elem_done = 1'b1;
				state_d        = stat.k_last ? ST_EMIT_RD : ST_IDLE;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (stat.out_free) begin
					ctrl.emit_load = 1'b1;
					state_d        = stat.j_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/sqmm_datapath.sv
`timescale 1ns / 1ps
// Datapath of the square matrix multiplier: B store, row accumulators, shared MAC,
// index counters and the output register. Depends on sqmm_pkg.
module sqmm_datapath import sqmm_pkg::*; #(
	parameter int MAX_SIZE      = 32,
	parameter int ELEMENT_WIDTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            matrix_size_we,
	input  logic [SIZE_W-1:0]               matrix_size,
	input  logic signed [ELEMENT_WIDTH-1:0] value,
	input  ctrl_t                           ctrl,
	output stat_t                           stat,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [PRODUCT_W-1:0]     product,
	output logic [INDEX_W-1:0]              row,
	output logic [INDEX_W-1:0]              col,
	output logic                            last_in_row
);

	localparam int DEPTH   = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int TOT_W   = ADDR_W + 1;
	localparam int CNT_W   = $clog2(MAX_SIZE + 1);
	localparam int IDX_W   = $clog2(MAX_SIZE);
	localparam int MUL_W   = 2 * ELEMENT_WIDTH;
	localparam int EXT_W   = (MUL_W > PRODUCT_W) ? MUL_W : PRODUCT_W;
	localparam int RESET_N = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;
	localparam int RESET_T = RESET_N * RESET_N;

	logic signed [ELEMENT_WIDTH-1:0] b_mem [DEPTH];
	logic signed [PRODUCT_W-1:0]     acc_mem [MAX_SIZE];

	logic [CNT_W-1:0]    n_q;
	logic [TOT_W-1:0]    total_q;
	logic [TOT_W-1:0]    bcnt_q;
	logic [IDX_W-1:0]    j_q;
	logic [IDX_W-1:0]    k_q;
	logic [IDX_W-1:0]    row_q;
	logic [ADDR_W-1:0]   base_q;
	logic [MAX_SIZE-1:0] acc_vld_q;
	logic                mac_s1;
	logic                out_valid_q;

	logic signed [ELEMENT_WIDTH-1:0] a_q;
	logic signed [ELEMENT_WIDTH-1:0] b_rd_s1;
	logic signed [PRODUCT_W-1:0]     acc_rd_s1;
	logic                            acc_vld_s1;
	logic [IDX_W-1:0]                j_s1;
	logic signed [PRODUCT_W-1:0]     product_q;
	logic [INDEX_W-1:0]              row_q_out;
	logic [INDEX_W-1:0]              col_q;
	logic                            last_q;

	logic [CNT_W-1:0]            n_new;
	logic [TOT_W-1:0]            total_new;
	logic [TOT_W-1:0]            bcnt_inc;
	logic [IDX_W-1:0]            last_idx;
	logic [ADDR_W-1:0]           b_rd_addr;
	logic signed [MUL_W-1:0]     mul_prod;
	logic signed [EXT_W-1:0]     prod_ext;
	logic signed [PRODUCT_W-1:0] acc_base;
	logic signed [PRODUCT_W-1:0] acc_sum;

	always_comb begin
		if (matrix_size == '0) begin
			n_new = CNT_W'(1);
		end else if (int'(matrix_size) > MAX_SIZE) begin
			n_new = CNT_W'(MAX_SIZE);
		end else begin
			n_new = CNT_W'(matrix_size);
		end
	end

	assign total_new = TOT_W'(n_new) * TOT_W'(n_new);
	assign bcnt_inc  = bcnt_q + TOT_W'(1);
	assign last_idx  = IDX_W'(n_q - CNT_W'(1));
	assign b_rd_addr = base_q + ADDR_W'(j_q);

	assign mul_prod = a_q * b_rd_s1;
	assign prod_ext = EXT_W'(mul_prod);
	assign acc_base = acc_vld_s1 ? acc_rd_s1 : '0;
	assign acc_sum  = acc_base + prod_ext[PRODUCT_W-1:0];

	assign stat.j_last   = (j_q == last_idx);
	assign stat.k_last   = (k_q == last_idx);
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (ctrl.load_b) begin
			b_mem[bcnt_q[ADDR_W-1:0]] <= value;
		end
		if (mac_s1) begin
			acc_mem[j_s1] <= acc_sum;
		end
		b_rd_s1    <= b_mem[b_rd_addr];
		acc_rd_s1  <= acc_mem[j_q];
		acc_vld_s1 <= acc_vld_q[j_q];
		j_s1       <= j_q;
		if (ctrl.load_a) begin
			a_q <= value;
		end
		if (ctrl.emit_load) begin
			product_q <= acc_vld_s1 ? acc_rd_s1 : '0;
			row_q_out <= INDEX_W'(row_q);
			col_q     <= INDEX_W'(j_q);
			last_q    <= stat.j_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= CNT_W'(RESET_N);
			total_q   <= TOT_W'(RESET_T);
			bcnt_q    <= '0;
			j_q       <= '0;
			k_q       <= '0;
			row_q     <= '0;
			base_q    <= '0;
			acc_vld_q <= '0;
			mac_s1    <= 1'b0;
		end else if (matrix_size_we) begin
			n_q       <= n_new;
			total_q   <= total_new;
			bcnt_q    <= '0;
			j_q       <= '0;
			k_q       <= '0;
			row_q     <= '0;
			base_q    <= '0;
			acc_vld_q <= '0;
			mac_s1    <= 1'b0;
		end else begin
			mac_s1 <= ctrl.mac_step;
			if (ctrl.load_b) begin
				bcnt_q <= (bcnt_inc == total_q) ? '0 : bcnt_inc;
			end
			if (ctrl.load_a) begin
				j_q <= '0;
			end
			if (ctrl.mac_step && !stat.j_last) begin
				j_q <= j_q + IDX_W'(1);
			end
			if (mac_s1) begin
				acc_vld_q[j_s1] <= 1'b1;
			end
			if (ctrl.elem_done) begin
				j_q <= '0;
				if (stat.k_last) begin
					k_q    <= '0;
					base_q <= '0;
				end else begin
					k_q    <= k_q + IDX_W'(1);
					base_q <= base_q + ADDR_W'(n_q);
				end
			end
			if (ctrl.emit_load) begin
				if (stat.j_last) begin
					j_q       <= '0;
					acc_vld_q <= '0;
					row_q     <= (row_q == last_idx) ? '0 : row_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign product     = product_q;
	assign row         = row_q_out;
	assign col         = col_q;
	assign last_in_row = last_q;

	a_bcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q < total_q)
		else $error("B load count reached the element total");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(TOT_W'(j_q) < TOT_W'(n_q)) && (TOT_W'(k_q) < TOT_W'(n_q))
		&& (TOT_W'(row_q) < TOT_W'(n_q)))
		else $error("Index counter beyond the matrix order");

	a_row_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit_load && stat.j_last |=> $countones(acc_vld_q) == 0)
		else $error("Accumulators not cleared after the last item of a row");

	a_mac_quiet_emit: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit_load |-> !mac_s1)
		else $error("Accumulator write during row emission");

endmodule

>>> src/square_matrix_multiply.sv
`timescale 1ns / 1ps
// Top level of the square matrix multiplier, C = A x B of configured order n.
// Depends on sqmm_pkg, sqmm_ctrl and sqmm_datapath.
//
//   channel   handshake                 payload
//   input     in_valid / in_ready       cmd, value
//   output    out_valid / out_ready     product, row, col, last_in_row
//   config    matrix_size_we            matrix_size
//
// A B item is stored as it is accepted. An A item is accepted, then goes through the
// single shared multiply-accumulate unit, one column per cycle, and then drains.
// The n-th A item of a row is followed by row emission: a read state for the registered
// accumulator read, then a write state per item that waits while out_ready stays low.
// Reset needs no clearing pass; B store contents stay undefined until loaded.
module square_matrix_multiply import sqmm_pkg::*; #(
	parameter int MAX_SIZE      = 32,
	parameter int ELEMENT_WIDTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            matrix_size_we,
	input  logic [SIZE_W-1:0]               matrix_size,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            cmd,
	input  logic signed [ELEMENT_WIDTH-1:0] value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [PRODUCT_W-1:0]     product,
	output logic [INDEX_W-1:0]              row,
	output logic [INDEX_W-1:0]              col,
	output logic                            last_in_row
);

	ctrl_t ctrl;
	stat_t stat;

	sqmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_ready (in_ready),
		.ctrl     (ctrl),
		.stat     (stat)
	);

	sqmm_datapath #(
		.MAX_SIZE      (MAX_SIZE),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.matrix_size_we (matrix_size_we),
		.matrix_size    (matrix_size),
		.value          (value),
		.ctrl           (ctrl),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.product        (product),
		.row            (row),
		.col            (col),
		.last_in_row    (last_in_row)
	);

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for square_matrix_multiply: B loads, A rows and several sizes.
// Depends on sqmm_pkg and the RTL under src; a scoreboard class predicts every element of C.
module testbench;
	import sqmm_pkg::*;

	localparam int MAX_SIZE      = 32;
	localparam int ELEMENT_WIDTH = 8;
	localparam int SETTLE_CYCLES = 2 * MAX_SIZE + 8;
	localparam int HOLD_CYCLES   = 500;
	localparam int RANDOM_ITEMS  = 150;
	localparam int TIME_LIMIT_NS = 2000000;

	typedef struct {
		logic signed [PRODUCT_W-1:0] product;
		logic [INDEX_W-1:0]          row;
		logic [INDEX_W-1:0]          col;
		logic                        last;
	} c_elem_t;

	class product_scoreboard;
		c_elem_t                         expected_elems[$];
		int unsigned                     order;
		logic signed [ELEMENT_WIDTH-1:0] b_matrix [MAX_SIZE*MAX_SIZE];
		bit                              b_written [MAX_SIZE*MAX_SIZE];
		int                              row_sum [MAX_SIZE];
		int unsigned                     b_count, a_col, a_row;
		int                              errors, b_items, a_items, rows_done;

		function new();
			foreach (b_written[i]) b_written[i] = 1'b0;
			order = SIZE_RESET;
			errors = 0;
			b_items = 0;
			a_items = 0;
			rows_done = 0;
			clear_progress();
		endfunction

		function void clear_progress();
			foreach (row_sum[j]) row_sum[j] = 0;
			b_count = 0;
			a_col = 0;
			a_row = 0;
		endfunction

		function void set_size(logic [SIZE_W-1:0] code);
			if (code == 0) order = 1;
			else if (code > MAX_SIZE) order = MAX_SIZE;
			else order = code;
			clear_progress();
		endfunction

		function bit b_ready();
			for (int i = 0; i < order * order; i++)
				if (!b_written[i]) return 1'b0;
			return 1'b1;
		endfunction

		function int pending();
			return expected_elems.size();
		endfunction

		function void note_item(logic c, logic signed [ELEMENT_WIDTH-1:0] v);
			c_elem_t elem;
			if (c == CMD_B) begin
				if (b_count >= order * order) b_count = 0;
				b_matrix[b_count] = v;
				b_written[b_count] = 1'b1;
				b_count++;
				if (b_count >= order * order) b_count = 0;
				b_items++;
				return;
			end
			a_items++;
			for (int j = 0; j < order; j++)
				row_sum[j] += int'(v) * int'(b_matrix[a_col * order + j]);
			a_col++;
			if (a_col < order) return;
			for (int j = 0; j < order; j++) begin
				elem.product = row_sum[j][PRODUCT_W-1:0];
				elem.row = a_row[INDEX_W-1:0];
				elem.col = j[INDEX_W-1:0];
				elem.last = (j == order - 1);
				expected_elems.push_back(elem);
				row_sum[j] = 0;
			end
			a_col = 0;
			a_row++;
			if (a_row >= order) a_row = 0;
			rows_done++;
		endfunction

		function void check_element(logic signed [PRODUCT_W-1:0] p, logic [INDEX_W-1:0] r,
				logic [INDEX_W-1:0] c, logic l);
			c_elem_t want;
			if (expected_elems.size() == 0) begin
				$display("%0t: unexpected C element: product %0d row %0d col %0d",
					$time, p, r, c);
				errors++;
				return;
			end
			want = expected_elems.pop_front();
			if (p !== want.product) begin
				$display("%0t: product of C[%0d][%0d]: expected %0d, actual %0d",
					$time, want.row, want.col, want.product, p);
				errors++;
			end
			if (r !== want.row) begin
				$display("%0t: row: expected %0d, actual %0d", $time, want.row, r);
				errors++;
			end
			if (c !== want.col) begin
				$display("%0t: col: expected %0d, actual %0d", $time, want.col, c);
				errors++;
			end
			if (l !== want.last) begin
				$display("%0t: last_in_row of C[%0d][%0d]: expected %0b, actual %0b",
					$time, want.row, want.col, want.last, l);
				errors++;
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            matrix_size_we;
	logic [SIZE_W-1:0]               matrix_size;
	logic                            in_valid;
	logic                            in_ready;
	logic                            cmd;
	logic signed [ELEMENT_WIDTH-1:0] value;
	logic                            out_valid;
	logic                            out_ready;
	logic signed [PRODUCT_W-1:0]     product;
	logic [INDEX_W-1:0]              row;
	logic [INDEX_W-1:0]              col;
	logic                            last_in_row;

	product_scoreboard board;
	int send_calm;
	int random_items;
	int settings_used;
	bit hold_output;

	square_matrix_multiply #(
		.MAX_SIZE(MAX_SIZE),
		.ELEMENT_WIDTH(ELEMENT_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.matrix_size_we(matrix_size_we),
		.matrix_size(matrix_size),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.product(product),
		.row(row),
		.col(col),
		.last_in_row(last_in_row)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int draw_gap(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 8);
	endfunction

	function automatic logic signed [ELEMENT_WIDTH-1:0] rand_element();
		case ($urandom_range(0, 5))
			0: return 8'h80;
			1: return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic c, input logic signed [ELEMENT_WIDTH-1:0] v);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_item(c, v);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] code);
		drain_results();
		matrix_size_we <= 1'b1;
		matrix_size <= code;
		@(posedge clk);
		board.set_size(code);
		matrix_size_we <= 1'b0;
		settings_used++;
	endtask

	task automatic run_phase(input logic [SIZE_W-1:0] code, input int count, input bit hold);
		logic c;
		write_size(code);
		if (hold) hold_output = 1'b1;
		repeat (count) begin
			if (!board.b_ready()) c = CMD_B;
			else if ($urandom_range(0, 7) == 0) c = CMD_B;
			else c = CMD_A;
			send_item(c, rand_element());
			random_items++;
		end
	endtask

	initial begin : receiver
		int gap;
		int calm;
		bit held;
		gap = 0;
		calm = 0;
		held = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				board.check_element(product, row, col, last_in_row);
				gap = draw_gap(calm);
			end else if (gap > 0) begin
				gap--;
			end
			if (hold_output && !held) begin
				held = 1'b1;
				gap = HOLD_CYCLES;
			end
			out_ready <= (gap == 0);
		end
	end

	initial begin
		#(TIME_LIMIT_NS);
		$display("Timeout with %0d C elements still expected", board.pending());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		logic [SIZE_W-1:0] code;
		int n;
		board = new();
		send_calm = 0;
		random_items = 0;
		settings_used = 0;
		hold_output = 1'b0;
		arst_n = 1'b0;
		matrix_size_we = 1'b0;
		matrix_size = '0;
		in_valid = 1'b0;
		cmd = CMD_B;
		value = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme elements at order 2; a later B item overwrites B[0][0] after the load pointer wrapped.
		write_size(2);
		send_item(CMD_B, 8'h80);
		send_item(CMD_B, 8'h7F);
		send_item(CMD_B, 8'h7F);
		send_item(CMD_B, 8'h80);
		send_item(CMD_A, 8'h80);
		send_item(CMD_A, 8'h80);
		send_item(CMD_A, 8'h7F);
		send_item(CMD_A, 8'h7F);
		send_item(CMD_B, 8'h00);
		send_item(CMD_A, 8'hFF);
		send_item(CMD_A, 8'h00);

		// A size of zero behaves as order 1.
		write_size(0);
		send_item(CMD_B, 8'h80);
		send_item(CMD_A, 8'h80);
		send_item(CMD_A, 8'h7F);

		// Order 3 with a row left unfinished when the size is written again.
		write_size(3);
		repeat (9) send_item(CMD_B, rand_element());
		send_item(CMD_A, rand_element());
		send_item(CMD_A, rand_element());

		run_phase(4, 16 + 4 * 4, 1'b1);
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: code = 0;
				1: code = SIZE_W'($urandom_range(6, 8));
				default: code = SIZE_W'($urandom_range(1, 5));
			endcase
			n = (code == 0) ? 1 : code;
			run_phase(code, n * n + $urandom_range(1, 4) * n + $urandom_range(0, 2), 1'b0);
		end

		// An oversized code acts as the largest order; two A items use the first
		// two rows of B and must not complete a row.
		write_size(63);
		repeat (2 * MAX_SIZE) send_item(CMD_B, rand_element());
		send_item(CMD_A, rand_element());
		send_item(CMD_A, rand_element());
		run_phase(1, 12, 1'b0);

		drain_results();
		$display("Sent %0d B items and %0d A items across %0d size settings.",
			board.b_items, board.a_items, settings_used);
		$display("Predicted and compared %0d rows of C.", board.rows_done);
		if (board.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
